// ===== sv/pcbb_pkg.sv =====
// Shared widths, constants and payload types for the periodic cubic B-spline basis block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcbb_pkg;

	localparam int MAX_SEGMENTS = 1024;
	localparam int SEG_W        = 11;
	localparam int N_W          = $clog2(MAX_SEGMENTS + 1);
	localparam int U_W          = 16;
	localparam int T_W          = 16;
	localparam int K_W          = 10;
	localparam int IDX_W        = 11;
	localparam int W_W          = 17;
	localparam int A_W          = T_W + 1;
	localparam int SQ_W         = 2 * T_W + 1;
	localparam int CUBE_W       = 3 * T_W + 1;
	localparam int X_W          = CUBE_W + 1;
	localparam int SUM_W        = X_W + 1;
	localparam int ROUND_SHIFT  = 2 * T_W + 1;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic REG_SEGMENT_COUNT = 1'b0;
	localparam logic [SEG_W-1:0] SEGMENT_COUNT_RESET = SEG_W'(4);

	typedef struct packed {
		logic [K_W-1:0] k;
		logic [T_W-1:0] t;
		logic [N_W-1:0] n;
	} seg_t;

	typedef struct packed {
		logic [K_W-1:0]   segment_index;
		logic [IDX_W-1:0] first_index;
		logic [W_W-1:0]   weight_a;
		logic [W_W-1:0]   weight_b;
		logic [W_W-1:0]   weight_c;
		logic [W_W-1:0]   weight_d;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/pcbb_in_if.sv =====
// Input channel: parameter u_frac with valid/ready handshake.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pcbb_in_if;
	logic                    valid;
	logic                    ready;
	logic [pcbb_pkg::U_W-1:0] u_frac;

	modport source (output valid, output u_frac, input ready);
	modport sink   (input valid, input u_frac, output ready);
endinterface
`default_nettype wire

// ===== sv/pcbb_out_if.sv =====
// Output channel: segment, first control point index and four Q1.16 weights.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pcbb_out_if;
	logic                      valid;
	logic                      ready;
	logic [pcbb_pkg::K_W-1:0]   segment_index;
	logic [pcbb_pkg::IDX_W-1:0] first_index;
	logic [pcbb_pkg::W_W-1:0]   weight_a;
	logic [pcbb_pkg::W_W-1:0]   weight_b;
	logic [pcbb_pkg::W_W-1:0]   weight_c;
	logic [pcbb_pkg::W_W-1:0]   weight_d;

	modport source (output valid, output segment_index, output first_index,
		output weight_a, output weight_b, output weight_c, output weight_d, input ready);
	modport sink   (input valid, input segment_index, input first_index,
		input weight_a, input weight_b, input weight_c, input weight_d, output ready);
endinterface
`default_nettype wire

// ===== sv/pcbb_apb_regs.sv =====
// APB register file: segment_count, plus its clamped value N in 1..MAX_SEGMENTS.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcbb_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcbb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pcbb_pkg::PDATA_W-1:0]  pwdata,
	output logic [pcbb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [pcbb_pkg::N_W-1:0]      seg_n
);
	import pcbb_pkg::*;

	logic [SEG_W-1:0] seg_count_q;
	logic             hit;

	assign pready = 1'b1;
	assign hit    = (paddr[PADDR_W-1] == REG_SEGMENT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEGMENT_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			seg_count_q <= pwdata[SEG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = PDATA_W'(seg_count_q);
		end
	end

	// zero counts as one segment, large counts clamp
	always_comb begin
		priority if (seg_count_q == '0) begin
			seg_n = N_W'(1);
		end else if (SEG_W'(seg_count_q) > SEG_W'(MAX_SEGMENTS)) begin
			seg_n = N_W'(MAX_SEGMENTS);
		end else begin
			seg_n = N_W'(seg_count_q);
		end
	end

endmodule
`default_nettype wire

// ===== sv/pcbb_segment.sv =====
// Stages 1-2: register u and N, then s = u*N split into segment k and local t.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcbb_segment (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pcbb_pkg::U_W-1:0]  u_frac,
	input  logic [pcbb_pkg::N_W-1:0]  seg_n,
	output logic                      out_valid,
	input  logic                      out_ready,
	output pcbb_pkg::seg_t            out_seg
);
	import pcbb_pkg::*;

	logic               v_s1, v_s2;
	logic               en_s1, en_s2;
	logic [U_W-1:0]     u_s1;
	logic [N_W-1:0]     n_s1;
	logic [U_W+N_W-1:0] prod;
	seg_t               seg_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign prod     = u_s1 * n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			u_s1 <= u_frac;
			n_s1 <= seg_n;
		end
		if (en_s2) begin
			seg_s2.k <= prod[U_W+K_W-1:U_W];
			seg_s2.t <= prod[T_W-1:0];
			seg_s2.n <= n_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_seg   = seg_s2;

endmodule
`default_nettype wire

// ===== sv/pcbb_weights.sv =====
// Stages 3-6: squares and index, cubes, exact weights, single-segment fold and rounding.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcbb_weights (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcbb_pkg::seg_t   in_seg,
	output logic             out_valid,
	input  logic             out_ready,
	output pcbb_pkg::res_t   out_res
);
	import pcbb_pkg::*;

	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (ROUND_SHIFT - 1);

	logic v_s3, v_s4, v_s5, v_s6;
	logic en_s3, en_s4, en_s5, en_s6;

	// stage 3
	logic [A_W-1:0]     a;
	logic [2*A_W-1:0]   a_sq_full;
	logic [2*T_W-1:0]   b_sq_full;
	logic [IDX_W:0]     idx_full;
	logic [A_W-1:0]     a_s3;
	logic [T_W-1:0]     b_s3;
	logic [SQ_W-1:0]    a2_s3, b2_s3;
	logic [K_W-1:0]     k_s3, k_s4, k_s5;
	logic [IDX_W-1:0]   idx_s3, idx_s4, idx_s5;
	logic               single_s3, single_s4, single_s5;
	// stage 4
	logic [CUBE_W-1:0]  c0_s4, c1_s4, c2_s4, c3_s4;
	// stage 5
	logic [X_W-1:0]     xa_s5, xb_s5, xc_s5, xd_s5;
	// stage 6
	logic [SUM_W-1:0]   pa, pb, pc, pd;
	res_t               res_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign a         = (A_W'(1) << T_W) - A_W'(in_seg.t);
	assign a_sq_full = a * a;
	assign b_sq_full = in_seg.t * in_seg.t;
	assign idx_full  = (in_seg.k == '0) ? ({in_seg.n, 1'b0} - (IDX_W+1)'(1))
	                                    : ({1'b0, in_seg.k, 1'b0} - (IDX_W+1)'(1));

	always_comb begin
		if (single_s5) begin
			pa = SUM_W'(xa_s5) + SUM_W'(xc_s5) + ROUND_HALF;
			pb = SUM_W'(xb_s5) + SUM_W'(xd_s5) + ROUND_HALF;
		end else begin
			pa = SUM_W'(xa_s5) + ROUND_HALF;
			pb = SUM_W'(xb_s5) + ROUND_HALF;
		end
		pc = SUM_W'(xc_s5) + ROUND_HALF;
		pd = SUM_W'(xd_s5) + ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			a_s3      <= a;
			b_s3      <= in_seg.t;
			a2_s3     <= a_sq_full[SQ_W-1:0];
			b2_s3     <= SQ_W'(b_sq_full);
			k_s3      <= in_seg.k;
			idx_s3    <= idx_full[IDX_W-1:0];
			single_s3 <= (in_seg.n == N_W'(1));
		end
		if (en_s4) begin
			c0_s4     <= CUBE_W'(a2_s3 * a_s3);
			c1_s4     <= CUBE_W'(a2_s3 * b_s3);
			c2_s4     <= CUBE_W'(b2_s3 * a_s3);
			c3_s4     <= CUBE_W'(b2_s3 * b_s3);
			k_s4      <= k_s3;
			idx_s4    <= idx_s3;
			single_s4 <= single_s3;
		end
		if (en_s5) begin
			// units of 2^-49: a^3, a^3 + 6a^2b, 6ab^2 + b^3, b^3
			xa_s5     <= X_W'(c0_s4);
			xb_s5     <= X_W'(c0_s4) + (X_W'(c1_s4) << 2) + (X_W'(c1_s4) << 1);
			xc_s5     <= X_W'(c3_s4) + (X_W'(c2_s4) << 2) + (X_W'(c2_s4) << 1);
			xd_s5     <= X_W'(c3_s4);
			k_s5      <= k_s4;
			idx_s5    <= idx_s4;
			single_s5 <= single_s4;
		end
		if (en_s6) begin
			res_s6.segment_index <= k_s5;
			res_s6.first_index   <= idx_s5;
			res_s6.weight_a      <= pa[W_W+ROUND_SHIFT-1:ROUND_SHIFT];
			res_s6.weight_b      <= pb[W_W+ROUND_SHIFT-1:ROUND_SHIFT];
			res_s6.weight_c      <= single_s5 ? '0 : pc[W_W+ROUND_SHIFT-1:ROUND_SHIFT];
			res_s6.weight_d      <= single_s5 ? '0 : pd[W_W+ROUND_SHIFT-1:ROUND_SHIFT];
		end
	end

	assign out_valid = v_s6;
	assign out_res   = res_s6;

	logic [W_W+1:0] w_total;
	assign w_total = (W_W+2)'(res_s6.weight_a) + (W_W+2)'(res_s6.weight_b)
	               + (W_W+2)'(res_s6.weight_c) + (W_W+2)'(res_s6.weight_d);

	// weights partition unity to within the four roundings
	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (w_total >= (W_W+2)'(65534)) && (w_total <= (W_W+2)'(65538)))
		else $error("basis weights do not sum to one");

	// single segment folds onto two points
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en_s6 && single_s5) |=> (res_s6.weight_c == '0) && (res_s6.weight_d == '0))
		else $error("single segment left weight in the upper slots");

	// an item held in a stalled stage stays there
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en_s5) |=> v_s5)
		else $error("stalled stage 5 lost its item");

	// a stage that moves on hands its item forward
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> v_s5)
		else $error("item dropped between stages 4 and 5");

endmodule
`default_nettype wire

// ===== sv/periodic_cubic_bspline_basis.sv =====
// Periodic cubic B-spline basis: segment, control point index and four Q1.16 weights per u.
// Each request passes register stages s1 to s6 in order before its result is valid.
// Throughput: one request per cycle unless stalled; six register stages, each may stall.
// Reset (arst_n low, asynchronous): pipeline emptied, segment_count back to 4.
// Depends on pcbb_pkg, pcbb_in_if, pcbb_out_if, pcbb_apb_regs, pcbb_segment, pcbb_weights.
`timescale 1ns / 1ps
`default_nettype none
module periodic_cubic_bspline_basis (
	input  logic                          clk,
	input  logic                          arst_n,
	pcbb_in_if.sink                       u_in,
	pcbb_out_if.source                    basis_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcbb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pcbb_pkg::PDATA_W-1:0]  pwdata,
	output logic [pcbb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import pcbb_pkg::*;

	logic [N_W-1:0] seg_n;
	logic           seg_valid, seg_ready;
	seg_t           seg;
	res_t           res;

	pcbb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seg_n   (seg_n)
	);

	pcbb_segment u_segment (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (u_in.valid),
		.in_ready  (u_in.ready),
		.u_frac    (u_in.u_frac),
		.seg_n     (seg_n),
		.out_valid (seg_valid),
		.out_ready (seg_ready),
		.out_seg   (seg)
	);

	pcbb_weights u_weights (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.in_seg    (seg),
		.out_valid (basis_out.valid),
		.out_ready (basis_out.ready),
		.out_res   (res)
	);

	assign basis_out.segment_index = res.segment_index;
	assign basis_out.first_index   = res.first_index;
	assign basis_out.weight_a      = res.weight_a;
	assign basis_out.weight_b      = res.weight_b;
	assign basis_out.weight_c      = res.weight_c;
	assign basis_out.weight_d      = res.weight_d;

endmodule
`default_nettype wire
